[hdl/kdb_pkg.sv]
// Shared types and constants for the knob average, scale and deadband block.
package kdb_pkg;

    localparam int SAMPLE_W = 12;
    localparam int DUTY_W   = 8;
    localparam int PROD_W   = SAMPLE_W + DUTY_W;

    localparam logic [DUTY_W-1:0]   DUTY_MAX = 8'd255;
    localparam logic [SAMPLE_W-1:0] RAW_MAX  = 12'd4095;

    // Configuration register indexes.
    localparam logic REG_DEADBAND  = 1'b0;
    localparam logic REG_INIT_DUTY = 1'b1;

    localparam logic [DUTY_W-1:0] DEADBAND_RST  = 8'd2;
    localparam logic [DUTY_W-1:0] INIT_DUTY_RST = 8'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MEAN,
        S_SCALE,
        S_FIN
    } t_state;

endpackage

[hdl/knob_average_scale_deadband_core.sv]
// Block averager with scaling to 0..255 and a deadband on the held duty.
//
// Samples are taken one per cycle while the input is ready, SAMPLES_PER_GROUP
// to a group. After the last request of a group with at least one good
// sample, the block runs its one bit-serial divider for sum / count over
// DIV_W bits: 12 plus the width of the good-sample count, so 17 at the
// default setting and 21 for groups of 256 to 511. The scaling by 255 / 4095
// is then a shift-and-subtract and a shift-and-add, registered in r_prod and
// then r_duty_new, and the result register loads from r_duty_new once the
// output slot is free. The result becomes valid and the input is ready again
// at the same point. A group with no good sample gives its result at once.
// The input is not ready during the divider pass and the scaling steps; while
// a result waits on the output, only the last request of a group is held off.
module knob_average_scale_deadband_core #(
    parameter int SAMPLES_PER_GROUP = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sample, [15:12] zero
    input  logic        s_axis_tuser,   // [0] sample_ok
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] duty
    output logic [1:0]  m_axis_tuser,   // [0] changed, [1] no_samples
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    localparam int CNT_W  = $clog2(SAMPLES_PER_GROUP + 1);
    localparam int SUM_W  = kdb_pkg::SAMPLE_W + CNT_W;
    localparam int DIV_W  = SUM_W;
    localparam int DVS_W  = CNT_W;
    localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(SAMPLES_PER_GROUP - 1);

    kdb_pkg::t_state r_state, n_state;

    logic [SUM_W-1:0]           r_sum, n_sum;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [CNT_W-1:0]           r_pos, n_pos;
    logic [kdb_pkg::DUTY_W-1:0] r_held, n_held;
    logic                       r_first, n_first;
    logic [kdb_pkg::DUTY_W-1:0] r_deadband, n_deadband;
    logic [kdb_pkg::DUTY_W-1:0] r_init, n_init;
    logic [kdb_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [kdb_pkg::DUTY_W-1:0] r_duty_new, n_duty_new;
    logic                       r_out_valid, n_out_valid;
    logic [kdb_pkg::DUTY_W-1:0] r_out_duty, n_out_duty;
    logic                       r_out_changed, n_out_changed;
    logic                       r_out_none, n_out_none;

    logic                            in_fire;
    logic                            is_last;
    logic                            slot_free;
    logic [SUM_W-1:0]                sum_next;
    logic [CNT_W-1:0]                cnt_next;
    logic                            div_start;
    logic [DIV_W-1:0]                div_dividend;
    logic [DVS_W-1:0]                div_divisor;
    logic                            div_done;
    logic [DIV_W-1:0]                div_quo;
    logic [kdb_pkg::SAMPLE_W-1:0]    mean;
    logic [kdb_pkg::PROD_W-1:0]      prod;
    logic [kdb_pkg::PROD_W-1:0]      scale_sum;
    logic [kdb_pkg::DUTY_W-1:0]      diff;
    logic                            take;

    kdb_div #(
        .W (DIV_W),
        .D (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign is_last   = (r_pos == POS_LAST);
    assign slot_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == kdb_pkg::S_IDLE) && (!is_last || slot_free);
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    assign sum_next = s_axis_tuser
        ? r_sum + SUM_W'(s_axis_tdata[kdb_pkg::SAMPLE_W-1:0]) : r_sum;
    assign cnt_next = s_axis_tuser ? r_cnt + 1'b1 : r_cnt;

    // The mean never exceeds the largest sample, so its low bits hold it whole.
    assign mean = div_quo[kdb_pkg::SAMPLE_W-1:0];
    assign prod = {mean, 8'd0} - kdb_pkg::PROD_W'(mean);

    // With x = mean * 255 + 1, (x + (x >> 12)) >> 12 is exactly mean * 255 / 4095
    // truncated. The quotient tops out at 255, so it never needs a clamp.
    assign scale_sum = r_prod + (r_prod >> kdb_pkg::SAMPLE_W);

    assign diff = (r_duty_new >= r_held) ? r_duty_new - r_held : r_held - r_duty_new;
    assign take = !r_first || (diff >= r_deadband)
               || (r_duty_new == '0) || (r_duty_new == kdb_pkg::DUTY_MAX);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            kdb_pkg::S_IDLE: begin
                if (in_fire && is_last && (cnt_next != '0)) begin
                    n_state = kdb_pkg::S_MEAN;
                end
            end
            kdb_pkg::S_MEAN: begin
                if (div_done) begin
                    n_state = kdb_pkg::S_SCALE;
                end
            end
            kdb_pkg::S_SCALE: begin
                n_state = kdb_pkg::S_FIN;
            end
            kdb_pkg::S_FIN: begin
                if (slot_free) begin
                    n_state = kdb_pkg::S_IDLE;
                end
            end
            default: n_state = kdb_pkg::S_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        n_sum         = r_sum;
        n_cnt         = r_cnt;
        n_pos         = r_pos;
        n_held        = r_held;
        n_first       = r_first;
        n_deadband    = r_deadband;
        n_init        = r_init;
        n_prod        = r_prod;
        n_duty_new    = r_duty_new;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_duty    = r_out_duty;
        n_out_changed = r_out_changed;
        n_out_none    = r_out_none;
        div_start     = 1'b0;
        div_dividend  = DIV_W'(sum_next);
        div_divisor   = DVS_W'(cnt_next);

        if (i_cfg_we) begin
            case (i_cfg_idx)
                kdb_pkg::REG_DEADBAND: n_deadband = i_cfg_data;
                kdb_pkg::REG_INIT_DUTY: begin
                    n_init = i_cfg_data;
                    if (!r_first) begin
                        n_held = i_cfg_data;
                    end
                end
                default: n_deadband = r_deadband;
            endcase
        end

        case (r_state)
            kdb_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (is_last) begin
                        n_sum = '0;
                        n_cnt = '0;
                        n_pos = '0;
                        if (cnt_next == '0) begin
                            n_out_valid   = 1'b1;
                            n_out_duty    = r_held;
                            n_out_changed = 1'b0;
                            n_out_none    = 1'b1;
                        end else begin
                            div_start = 1'b1;
                        end
                    end else begin
                        n_sum = sum_next;
                        n_cnt = cnt_next;
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            kdb_pkg::S_MEAN: begin
                if (div_done) begin
                    n_prod = prod + 1'b1;
                end
            end
            kdb_pkg::S_SCALE: begin
                n_duty_new = scale_sum[kdb_pkg::PROD_W-1:kdb_pkg::SAMPLE_W];
            end
            kdb_pkg::S_FIN: begin
                if (slot_free) begin
                    n_out_valid   = 1'b1;
                    n_out_none    = 1'b0;
                    n_out_changed = take && (r_duty_new != r_held);
                    n_out_duty    = take ? r_duty_new : r_held;
                    if (take) begin
                        n_held  = r_duty_new;
                        n_first = 1'b1;
                    end
                end
            end
            default: n_out_valid = r_out_valid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kdb_pkg::S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_held      <= kdb_pkg::INIT_DUTY_RST;
            r_first     <= 1'b0;
            r_deadband  <= kdb_pkg::DEADBAND_RST;
            r_init      <= kdb_pkg::INIT_DUTY_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_held      <= n_held;
            r_first     <= n_first;
            r_deadband  <= n_deadband;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
        end
        r_prod        <= n_prod;
        r_duty_new    <= n_duty_new;
        r_out_duty    <= n_out_duty;
        r_out_changed <= n_out_changed;
        r_out_none    <= n_out_none;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_duty;
    assign m_axis_tuser  = {r_out_none, r_out_changed};

    // A group with no good sample can never report a new duty.
    a_none_not_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("changed and no_samples both set");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == kdb_pkg::S_IDLE))
        else $error("input ready outside idle");

    a_div_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_state == kdb_pkg::S_IDLE))
        else $error("divider started in wrong state");

    a_fin_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kdb_pkg::S_FIN && slot_free) |=> (m_axis_tvalid && !m_axis_tuser[1]))
        else $error("finished group gave no result");

    a_held_endpoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kdb_pkg::S_FIN && slot_free && r_duty_new == kdb_pkg::DUTY_MAX)
        |=> (r_held == kdb_pkg::DUTY_MAX))
        else $error("full-scale duty not taken");

endmodule

[hdl/kdb_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module kdb_div #(
    parameter int W = 20,
    parameter int D = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int STEP_W = (W > 1) ? $clog2(W) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [D-1:0]      r_rem, n_rem;
    logic [W-1:0]      r_quo, n_quo;
    logic [D-1:0]      r_dvs, n_dvs;

    logic [D:0] shifted;
    logic [D:0] trial;

    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        trial   = shifted - {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_step  = r_step;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so its top bit is never needed.
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = trial[D-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = shifted[D-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_step = r_step + 1'b1;
            if (r_step == STEP_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
